// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared constants and types of the stream find-and-replace block
// Field widths, register indexes and the job word that the window logic
// hands to the result emitter.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int DATA_W              = 8;
   localparam int REG_W               = 64;
   localparam int LEN_W               = 4;
   localparam int CSR_INDEX_W         = 4;
   localparam int WINDOW_MAX          = 8;
   localparam int PAT_SEL_W           = $clog2(REG_W / DATA_W);
   localparam int MAX_PATTERN_DEF     = 8;
   localparam int MAX_REPLACEMENT_DEF = 8;
   localparam int MAX_RESULTS         = 10;
   localparam int COUNT_W             = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_BYTES      = 4'd0,
      REG_PATTERN_LENGTH     = 4'd1,
      REG_REPLACEMENT_BYTES  = 4'd2,
      REG_REPLACEMENT_LENGTH = 4'd3
   } csr_reg_type;

   // Words owed for one accepted byte, in emission order: the displaced
   // oldest byte, the replacement, the flushed window, the end marker.
   typedef struct packed {
      logic              has_old;
      logic [DATA_W-1:0] old_byte;
      logic [LEN_W-1:0]  rep_cnt;
      logic [LEN_W-1:0]  flush_cnt;
      logic              last;
   } job_type;

endpackage

// ===== design/sfr_req_if.sv =====
// ----------------------------------------------------------------------------
// sfr_req_if: input text channel
// One text byte per word, with a flag on the last byte of a string.
// ----------------------------------------------------------------------------
interface sfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::DATA_W-1:0]  data_byte;
   logic                        end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ===== design/sfr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sfr_rsp_if: result channel
// One output text byte or the end marker per word.
// ----------------------------------------------------------------------------
interface sfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::DATA_W-1:0]  out_byte;
   logic                        byte_valid;
   logic                        last_result;

   modport source (output valid, output out_byte, output byte_valid, output last_result,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last_result,
                   output ready);
endinterface

// ===== design/sfr_csr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_csr_if: configuration write channel
// Carries a register index and the data to be written to it.
// ----------------------------------------------------------------------------
interface sfr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sfr_pkg::CSR_INDEX_W-1:0]  reg_index;
   logic [sfr_pkg::REG_W-1:0]        write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== design/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_cell: one position of the match window
// Holds one text byte, passes it on to the next cell when a byte is shifted
// in, and compares the byte arriving at its input with its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [sfr_pkg::DATA_W-1:0]  byte_in,
   input  logic [sfr_pkg::DATA_W-1:0]  cmp_byte,
   output logic [sfr_pkg::DATA_W-1:0]  byte_q,
   output logic                        hit
);
   import sfr_pkg::*;

   logic [DATA_W-1:0] byte_ff;
   logic [DATA_W-1:0] byte_in_next;

   assign byte_in_next = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   assign byte_q = byte_ff;
   // The compare looks at the value the cell will hold after the shift.
   assign hit    = (byte_in == cmp_byte);

endmodule

// ===== design/sfr_emitter.sv =====
// ----------------------------------------------------------------------------
// sfr_emitter: result sequencer and output register
// Works through the words owed for the last accepted byte, one per cycle while the output
// is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module sfr_emitter #(
   parameter int NUM_CELLS = sfr_pkg::WINDOW_MAX
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  sfr_pkg::job_type            job,
   input  logic [sfr_pkg::DATA_W-1:0]  cell_byte [NUM_CELLS],
   input  logic [sfr_pkg::REG_W-1:0]   replacement_bytes,
   input  logic [sfr_pkg::LEN_W-1:0]   rlen,
   output logic                        job_free,
   sfr_rsp_if.source                   rsp_chan
);
   import sfr_pkg::*;

   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

   logic              has_old_ff, has_old_in;
   logic [DATA_W-1:0] old_byte_ff, old_byte_in;
   logic [LEN_W-1:0]  rep_left_ff, rep_left_in;
   logic [LEN_W-1:0]  flush_left_ff, flush_left_in;
   logic              last_ff, last_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_byte_ff, out_byte_in;
   logic              out_bvalid_ff, out_bvalid_in;
   logic              out_last_ff, out_last_in;

   logic [COUNT_W-1:0]   count;
   logic                 pending;
   logic                 move;
   logic                 emit;
   logic [PAT_SEL_W-1:0] rep_idx;
   logic [IDX_W-1:0]     flush_idx;

   assign count = COUNT_W'(has_old_ff) + COUNT_W'(rep_left_ff)
                + COUNT_W'(flush_left_ff) + COUNT_W'(last_ff);
   assign pending   = (count != '0);
   assign move      = !out_valid_ff || rsp_chan.ready;
   assign emit      = move && pending;
   // A new byte may be taken when nothing is owed or the last word owed leaves in this cycle.
   assign job_free  = !pending || (move && (count == COUNT_W'(1)));
   assign rep_idx   = PAT_SEL_W'(rlen - rep_left_ff);
   assign flush_idx = IDX_W'(flush_left_ff - LEN_W'(1));

   always_comb begin
      has_old_in    = has_old_ff;
      old_byte_in   = old_byte_ff;
      rep_left_in   = rep_left_ff;
      flush_left_in = flush_left_ff;
      last_in       = last_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;

      if (move) begin
         out_valid_in = pending;
      end

      if (emit) begin
         out_bvalid_in = 1'b1;
         out_last_in   = 1'b0;
         if (has_old_ff) begin
            has_old_in  = 1'b0;
            out_byte_in = old_byte_ff;
         end else if (rep_left_ff != '0) begin
            rep_left_in = rep_left_ff - LEN_W'(1);
            out_byte_in = replacement_bytes[DATA_W*rep_idx +: DATA_W];
         end else if (flush_left_ff != '0) begin
            flush_left_in = flush_left_ff - LEN_W'(1);
            out_byte_in   = cell_byte[flush_idx];
         end else begin
            last_in       = 1'b0;
            out_byte_in   = '0;
            out_bvalid_in = 1'b0;
            out_last_in   = 1'b1;
         end
      end

      if (load) begin
         has_old_in    = job.has_old;
         old_byte_in   = job.old_byte;
         rep_left_in   = job.rep_cnt;
         flush_left_in = job.flush_cnt;
         last_in       = job.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_old_ff    <= 1'b0;
         rep_left_ff   <= '0;
         flush_left_ff <= '0;
         last_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         has_old_ff    <= has_old_in;
         rep_left_ff   <= rep_left_in;
         flush_left_ff <= flush_left_in;
         last_ff       <= last_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_byte_ff   <= old_byte_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.byte_valid  = out_bvalid_ff;
   assign rsp_chan.last_result = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= COUNT_W'(MAX_RESULTS))
      else $error("emitter owes more words than one byte can cause");

   a_idle_stays: assert property (@(posedge clock) disable iff (reset)
      (!pending && !load) |=> !pending)
      else $error("emitter found work without a new byte");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (!out_bvalid_ff && out_byte_ff == '0))
      else $error("end marker carries a text byte");

endmodule

// ===== design/stream_find_and_replace_top.sv =====
// ----------------------------------------------------------------------------
// stream_find_and_replace_top: streaming find-and-replace over a byte stream
// Words for a byte pass the emitter's job registers, then its output register.
// Throughput: one byte per cycle while the output is not stalled and each byte
// causes at most one word; more words hold the input until the last one leaves.
// Reset: synchronous; clears config, fill count and emitter; window bytes kept.
// ----------------------------------------------------------------------------
module stream_find_and_replace_top #(
   parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sfr_req_if.sink     req_chan,
   sfr_rsp_if.source   rsp_chan,
   sfr_csr_if.sink     csr_chan
);
   import sfr_pkg::*;

   localparam int NUM_CELLS = (MAX_PATTERN < WINDOW_MAX) ? MAX_PATTERN : WINDOW_MAX;
   localparam int REP_LIMIT = (MAX_REPLACEMENT < WINDOW_MAX) ? MAX_REPLACEMENT : WINDOW_MAX;
   localparam int FILL_W    = $clog2(NUM_CELLS + 1);
   localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

   logic [REG_W-1:0]  pattern_bytes_ff, pattern_bytes_in;
   logic [LEN_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [REG_W-1:0]  replacement_bytes_ff, replacement_bytes_in;
   logic [LEN_W-1:0]  replacement_length_ff, replacement_length_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              csr_write;
   logic              accept;
   logic              job_free;
   logic [LEN_W-1:0]  plen_wide;
   logic [FILL_W-1:0] plen;
   logic [LEN_W-1:0]  rlen;
   logic [FILL_W-1:0] eff_fill;
   logic              full;
   logic [FILL_W-1:0] new_fill;
   logic              match;
   job_type           job;

   logic [DATA_W-1:0]    cell_byte   [NUM_CELLS];
   logic [DATA_W-1:0]    cell_in     [NUM_CELLS];
   logic [DATA_W-1:0]    cell_cmp    [NUM_CELLS];
   logic [PAT_SEL_W-1:0] cell_sel    [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_hit;
   logic [NUM_CELLS-1:0] cell_active;

   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = job_free;

   // Lengths outside the usable range are clamped.
   always_comb begin
      if (pattern_length_ff == '0) begin
         plen_wide = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(NUM_CELLS)) begin
         plen_wide = LEN_W'(NUM_CELLS);
      end else begin
         plen_wide = pattern_length_ff;
      end
   end
   assign plen = FILL_W'(plen_wide);
   assign rlen = (replacement_length_ff > LEN_W'(REP_LIMIT)) ? LEN_W'(REP_LIMIT)
                                                              : replacement_length_ff;

   // The newest byte sits in cell 0, so cell i meets pattern byte plen-1-i.
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign cell_in[g] = req_chan.data_byte;
      end else begin : g_body
         assign cell_in[g] = cell_byte[g-1];
      end
      assign cell_sel[g]    = PAT_SEL_W'(plen - FILL_W'(1) - FILL_W'(g));
      assign cell_cmp[g]    = pattern_bytes_ff[DATA_W*cell_sel[g] +: DATA_W];
      assign cell_active[g] = (FILL_W'(g) < plen);

      sfr_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (cell_in[g]),
         .cmp_byte (cell_cmp[g]),
         .byte_q   (cell_byte[g]),
         .hit      (cell_hit[g])
      );
   end

   assign eff_fill = (fill_ff > plen) ? '0 : fill_ff;
   assign full     = (eff_fill >= plen);
   assign new_fill = full ? plen : eff_fill + FILL_W'(1);
   assign match    = (new_fill == plen) && (&(cell_hit | ~cell_active));

   always_comb begin
      job.has_old   = full;
      job.old_byte  = cell_byte[IDX_W'(plen - FILL_W'(1))];
      job.rep_cnt   = match ? rlen : '0;
      job.flush_cnt = (req_chan.end_of_text && !match) ? LEN_W'(new_fill) : '0;
      job.last      = req_chan.end_of_text;
   end

   always_comb begin
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      fill_in               = fill_ff;

      if (accept) begin
         fill_in = (match || req_chan.end_of_text) ? '0 : new_fill;
      end

      if (csr_write) begin
         case (csr_reg_type'(csr_chan.reg_index))
            REG_PATTERN_BYTES: begin
               pattern_bytes_in = csr_chan.write_data;
            end
            REG_PATTERN_LENGTH: begin
               // A new length drops whatever the window held.
               pattern_length_in = csr_chan.write_data[LEN_W-1:0];
               fill_in           = '0;
            end
            REG_REPLACEMENT_BYTES: begin
               replacement_bytes_in = csr_chan.write_data;
            end
            REG_REPLACEMENT_LENGTH: begin
               replacement_length_in = csr_chan.write_data[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= LEN_W'(1);
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
         fill_ff               <= '0;
      end else begin
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
         fill_ff               <= fill_in;
      end
   end

   sfr_emitter #(
      .NUM_CELLS (NUM_CELLS)
   ) u_emitter (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .job               (job),
      .cell_byte         (cell_byte),
      .replacement_bytes (replacement_bytes_ff),
      .rlen              (rlen),
      .job_free          (job_free),
      .rsp_chan          (rsp_chan)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= plen)
      else $error("window holds more bytes than the pattern length");

   a_end_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_text && !csr_write) |=> (fill_ff == '0))
      else $error("window not empty after the last byte of a string");

   a_full_stays: assert property (@(posedge clock) disable iff (reset)
      (accept && full && !req_chan.end_of_text && !match && !csr_write)
      |=> (fill_ff == $past(plen)))
      else $error("full window lost its fill without a match");

endmodule
